### hdl/bgv_pkg.sv
// Shared types, widths and register codes for the bilinear grid vertex generator.
// No dependencies; compiled first.
`default_nettype none
package bgv_pkg;

  localparam int RowW     = 10;   // grid_row / grid_col
  localparam int NW       = 11;   // effective division count
  localparam int CoordW   = 16;   // Q8.8 coordinate
  localparam int CfgW     = 48;   // widest register
  localparam int CfgIdxW  = 3;
  localparam int TexW     = 17;   // Q0.16 plus the value one
  localparam int QW       = 18;   // quotient bits, biased by 2^17 for positions
  localparam int RW       = 41;   // dividend / remainder
  localparam int DW       = 23;   // divisor, 2*n*n
  localparam int Axes     = 3;
  localparam int Lanes    = 5;    // x, y, z, u, v
  localparam int LaneU    = 3;
  localparam int LaneV    = 4;
  localparam int DefMaxDivisions = 1023;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CORNER_A  = 3'd0,
    REG_CORNER_B  = 3'd1,
    REG_CORNER_C  = 3'd2,
    REG_CORNER_D  = 3'd3,
    REG_DIVISIONS = 3'd4
  } cfg_reg_e;

  // Per-axis corner differences, signed.
  typedef struct packed {
    logic [Axes-1:0][16:0] da;   // D - A
    logic [Axes-1:0][16:0] ba;   // B - A
    logic [Axes-1:0][18:0] e;    // (C - B) - (D - A)
  } coef_t;

  // One stage of the divider pipe, all lanes.
  typedef struct packed {
    logic                        valid;
    logic                        clamped;
    logic [Lanes-1:0][RW-1:0]    rem;
    logic [Lanes-1:0][DW-1:0]    den;
    logic [Lanes-1:0][QW-1:0]    quo;
  } div_stage_t;

  typedef struct packed {
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic signed [CoordW-1:0] pos_z;
    logic [TexW-1:0]          tex_u;
    logic [TexW-1:0]          tex_v;
    logic                     clamped;
  } vertex_t;

endpackage
`default_nettype wire

### hdl/bgv_in_if.sv
// Grid point channel: valid/ready plus row and column.
// Depends on bgv_pkg.
`default_nettype none
interface bgv_in_if;
  import bgv_pkg::*;
  logic            valid;
  logic            ready;
  logic [RowW-1:0] grid_row;
  logic [RowW-1:0] grid_col;
  modport source (output valid, output grid_row, output grid_col, input ready);
  modport sink   (input valid, input grid_row, input grid_col, output ready);
endinterface
`default_nettype wire

### hdl/bgv_out_if.sv
// Vertex channel: valid/ready plus position, texture coordinates and clamp flag.
// Depends on bgv_pkg.
`default_nettype none
interface bgv_out_if;
  import bgv_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] pos_x;
  logic signed [CoordW-1:0] pos_y;
  logic signed [CoordW-1:0] pos_z;
  logic [TexW-1:0]          tex_u;
  logic [TexW-1:0]          tex_v;
  logic                     clamped;
  modport source (output valid, output pos_x, output pos_y, output pos_z,
                  output tex_u, output tex_v, output clamped, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                  input tex_u, input tex_v, input clamped, output ready);
endinterface
`default_nettype wire

### hdl/bgv_front.sv
// Front end: index clamp and the multiply stages that build each dividend.
// Depends on bgv_pkg.
`default_nettype none
module bgv_front (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    en,
  input  wire logic                    in_valid,
  input  wire logic [bgv_pkg::RowW-1:0] row,
  input  wire logic [bgv_pkg::RowW-1:0] col,
  input  wire logic [bgv_pkg::NW-1:0]   ndiv,
  input  wire bgv_pkg::coef_t           coef,
  output bgv_pkg::div_stage_t           dout
);
  import bgv_pkg::*;

  // stage 1
  logic            v1, f1;
  logic [RowW-1:0] r1, c1;
  logic [NW-1:0]   n1;
  // stage 2
  logic                  v2, f2;
  logic [RowW-1:0]       c2;
  logic [2*NW-2:0]       rn2;     // r*n, r < 2^10
  logic [2*NW-1:0]       nn2;
  logic [Axes-1:0][27:0] nba2;
  logic [Axes-1:0][28:0] re2;
  logic [1:0][27:0]      tnum2;
  logic [1:0][NW:0]      tden2;
  // stage 3
  logic                  v3, f3;
  logic [RowW-1:0]       c3;
  logic [2*NW-1:0]       nn3;
  logic [Axes-1:0][38:0] t1_3;
  logic [Axes-1:0][29:0] s3;
  logic [1:0][27:0]      tnum3;
  logic [1:0][NW:0]      tden3;
  // stage 4
  logic                  v4, f4;
  logic [2*NW-1:0]       nn4;
  logic [Axes-1:0][38:0] t1_4;
  logic [Axes-1:0][39:0] t2_4;
  logic [1:0][27:0]      tnum4;
  logic [1:0][NW:0]      tden4;

  logic signed [42:0]    num5 [Axes];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid; v2 <= v1; v3 <= v2; v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // clamp: if index > n then n < 1024, so it fits the index width
      r1 <= ({1'b0, row} > ndiv) ? ndiv[RowW-1:0] : row;
      c1 <= ({1'b0, col} > ndiv) ? ndiv[RowW-1:0] : col;
      f1 <= ({1'b0, row} > ndiv) || ({1'b0, col} > ndiv);
      n1 <= ndiv;

      f2  <= f1;
      c2  <= c1;
      rn2 <= (2*NW-1)'(r1) * (2*NW-1)'(n1);
      nn2 <= (2*NW)'(n1) * (2*NW)'(n1);
      for (int k = 0; k < Axes; k++) begin
        nba2[k] <= 28'($signed({1'b0, n1})) * 28'($signed(coef.ba[k]));
        re2[k]  <= 29'($signed({1'b0, r1})) * 29'($signed(coef.e[k]));
      end
      // u, v: (idx*2^17 + n) / (2n)
      tnum2[0] <= {1'b0, c1, 17'd0} + 28'(n1);
      tnum2[1] <= {1'b0, r1, 17'd0} + 28'(n1);
      tden2[0] <= {n1, 1'b0};
      tden2[1] <= {n1, 1'b0};

      f3    <= f2;
      c3    <= c2;
      nn3   <= nn2;
      tnum3 <= tnum2;
      tden3 <= tden2;
      for (int k = 0; k < Axes; k++) begin
        t1_3[k] <= 39'($signed({1'b0, rn2})) * 39'($signed(coef.da[k]));
        s3[k]   <= 30'($signed(nba2[k])) + 30'($signed(re2[k]));
      end

      f4    <= f3;
      nn4   <= nn3;
      tnum4 <= tnum3;
      tden4 <= tden3;
      for (int k = 0; k < Axes; k++) begin
        t1_4[k] <= t1_3[k];
        t2_4[k] <= 40'($signed({1'b0, c3})) * 40'($signed(s3[k]));
      end
    end
  end

  // Dividend 2*num + n^2, biased by 2^17 divisors so it is never negative.
  always_comb begin
    for (int k = 0; k < Axes; k++) begin
      num5[k] = 43'($signed(t1_4[k])) + 43'($signed(t2_4[k]));
      num5[k] = (num5[k] <<< 1) + $signed({19'd0, nn4, 1'b0} << 17)
              + $signed({21'd0, nn4});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout.clamped <= f4;
      for (int k = 0; k < Axes; k++) begin
        dout.rem[k] <= num5[k][RW-1:0];
        dout.den[k] <= {nn4, 1'b0};
        dout.quo[k] <= '0;
      end
      dout.rem[LaneU] <= RW'(tnum4[0]);
      dout.rem[LaneV] <= RW'(tnum4[1]);
      dout.den[LaneU] <= DW'(tden4[0]);
      dout.den[LaneV] <= DW'(tden4[1]);
      dout.quo[LaneU] <= '0;
      dout.quo[LaneV] <= '0;
    end
  end

endmodule
`default_nettype wire

### hdl/bgv_div_step.sv
// One restoring-division stage: resolves one quotient bit in every lane.
// Depends on bgv_pkg.
`default_nettype none
module bgv_div_step #(
  parameter int SHIFT = 0
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                en,
  input  wire bgv_pkg::div_stage_t din,
  output bgv_pkg::div_stage_t      dout
);
  import bgv_pkg::*;

  logic [Lanes-1:0][RW-1:0] trial;
  logic [Lanes-1:0]         take;

  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      trial[l] = RW'(din.den[l]) << SHIFT;
      take[l]  = din.rem[l] >= trial[l];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout.clamped <= din.clamped;
      dout.den     <= din.den;
      for (int l = 0; l < Lanes; l++) begin
        dout.rem[l] <= take[l] ? din.rem[l] - trial[l] : din.rem[l];
        dout.quo[l] <= {din.quo[l][QW-2:0], take[l]};
      end
    end
  end

endmodule
`default_nettype wire

### hdl/bgv_skid.sv
// Output register with a skid entry, so upstream ready is a flop.
// Depends on bgv_pkg and bgv_out_if.
`default_nettype none
module bgv_skid (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push_valid,
  input  wire bgv_pkg::vertex_t push_data,
  output logic                 push_ready,
  bgv_out_if.source            vertex
);
  import bgv_pkg::*;

  logic    out_valid, skid_valid;
  vertex_t out_data, skid_data;

  assign push_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (vertex.ready) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (out_valid && !vertex.ready) begin
      skid_valid <= push_valid;
    end else begin
      out_valid <= push_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (vertex.ready) begin
        out_data <= skid_data;
      end
    end else if (out_valid && !vertex.ready) begin
      skid_data <= push_data;
    end else begin
      out_data <= push_data;
    end
  end

  assign vertex.valid   = out_valid;
  assign vertex.pos_x   = out_data.pos_x;
  assign vertex.pos_y   = out_data.pos_y;
  assign vertex.pos_z   = out_data.pos_z;
  assign vertex.tex_u   = out_data.tex_u;
  assign vertex.tex_v   = out_data.tex_v;
  assign vertex.clamped = out_data.clamped;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid) else $error("skid entry held with empty output");
  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    skid_valid && vertex.ready |=> !skid_valid)
    else $error("skid entry not drained");
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    !skid_valid && push_valid && out_valid && !vertex.ready |=> skid_valid)
    else $error("beat dropped at the output");

endmodule
`default_nettype wire

### hdl/bilinear_grid_vertex_generator.sv
// Bilinear grid vertex generator: one quad grid point in, one vertex out.
//
// Channels: grid (sink) carries grid_row/grid_col; vertex (source) carries
// pos_x/y/z (signed Q8.8), tex_u/v (Q0.16, 65536 = one) and clamped.
// A beat moves when valid and ready are both high.
// Configuration: cfg_we, cfg_idx, cfg_wdata. Index 0..3 are corners A..D
// (x 15:0, y 31:16, z 47:32), 4 is divisions, clamped into 1..MAX_DIVISIONS
// as it is written. Other indexes are ignored. Write only while idle.
// Grid ready drops in the cycle after a write while the corner
// differences are re-registered.
// Throughput: one beat per clock while the vertex receiver does not stall.
// An accepted grid beat reaches its vertex beat through five clamp/multiply/add
// stages, 18 one-bit restoring division stages (2*n*n for positions, 2*n for
// texture) and the output register.
// Reset (rst, synchronous): corners 0, divisions 1, pipeline emptied.
// Receiver stall: the output register plus a skid entry absorb it; once
// the skid entry fills, the whole pipe holds and grid ready drops with it;
// nothing is lost or repeated. Bubbles are held along with the rest of the pipe.
// Depends on bgv_pkg, bgv_in_if, bgv_out_if, bgv_front, bgv_div_step, bgv_skid.
`default_nettype none
module bilinear_grid_vertex_generator #(
  parameter int MAX_DIVISIONS = bgv_pkg::DefMaxDivisions
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [bgv_pkg::CfgIdxW-1:0] cfg_idx,
  input  wire logic [bgv_pkg::CfgW-1:0]    cfg_wdata,
  bgv_in_if.sink                          grid,
  bgv_out_if.source                       vertex
);
  import bgv_pkg::*;

  logic [CfgW-1:0] corner_a, corner_b, corner_c, corner_d;
  logic [NW-1:0]   ndiv;
  logic            cfg_hold;     // cycle after a write: coefs settle
  coef_t           coef;
  logic            advance;      // whole-pipe enable
  logic            push_ready;
  div_stage_t      chain [QW+1];
  vertex_t         push_data;
  logic signed [CoordW+2:0] pos_w [Axes];

  // Config registers; divisions stored already clamped.
  always_ff @(posedge clk) begin
    if (rst) begin
      corner_a <= '0;
      corner_b <= '0;
      corner_c <= '0;
      corner_d <= '0;
      ndiv     <= NW'(1);
      cfg_hold <= 1'b0;
    end else begin
      cfg_hold <= cfg_we;
      if (cfg_we) begin
        case (cfg_idx)
          REG_CORNER_A: corner_a <= cfg_wdata;
          REG_CORNER_B: corner_b <= cfg_wdata;
          REG_CORNER_C: corner_c <= cfg_wdata;
          REG_CORNER_D: corner_d <= cfg_wdata;
          REG_DIVISIONS: begin
            if (cfg_wdata[NW-1:0] == '0) begin
              ndiv <= NW'(1);
            end else if (32'(cfg_wdata[NW-1:0]) > MAX_DIVISIONS) begin
              ndiv <= NW'(MAX_DIVISIONS);
            end else begin
              ndiv <= cfg_wdata[NW-1:0];
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Corner differences, re-registered from the corners every cycle.
  always_ff @(posedge clk) begin
    for (int k = 0; k < Axes; k++) begin
      coef.da[k] <= 17'($signed(corner_d[16*k +: 16])) - 17'($signed(corner_a[16*k +: 16]));
      coef.ba[k] <= 17'($signed(corner_b[16*k +: 16])) - 17'($signed(corner_a[16*k +: 16]));
      coef.e[k]  <= 19'($signed(corner_c[16*k +: 16])) - 19'($signed(corner_b[16*k +: 16]))
                  - 19'($signed(corner_d[16*k +: 16])) + 19'($signed(corner_a[16*k +: 16]));
    end
  end

  assign advance    = push_ready;
  assign grid.ready = push_ready && !cfg_hold;

  bgv_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (advance),
    .in_valid (grid.valid && grid.ready),
    .row      (grid.grid_row),
    .col      (grid.grid_col),
    .ndiv     (ndiv),
    .coef     (coef),
    .dout     (chain[0])
  );

  // Quotient bit QW-1 first, bit 0 last.
  for (genvar i = 0; i < QW; i++) begin : g_div
    bgv_div_step #(.SHIFT(QW-1-i)) u_step (
      .clk  (clk),
      .rst  (rst),
      .en   (advance),
      .din  (chain[i]),
      .dout (chain[i+1])
    );
  end

  // Remove the 2^17 bias, add corner A, saturate.
  always_comb begin
    for (int k = 0; k < Axes; k++) begin
      pos_w[k] = $signed({1'b0, chain[QW].quo[k]}) - (CoordW+3)'(32'sd131072)
               + (CoordW+3)'($signed(corner_a[16*k +: 16]));
    end
    push_data.pos_x   = (pos_w[0] > 19'sd32767) ? 16'sh7fff :
                        (pos_w[0] < -19'sd32768) ? 16'sh8000 : pos_w[0][CoordW-1:0];
    push_data.pos_y   = (pos_w[1] > 19'sd32767) ? 16'sh7fff :
                        (pos_w[1] < -19'sd32768) ? 16'sh8000 : pos_w[1][CoordW-1:0];
    push_data.pos_z   = (pos_w[2] > 19'sd32767) ? 16'sh7fff :
                        (pos_w[2] < -19'sd32768) ? 16'sh8000 : pos_w[2][CoordW-1:0];
    push_data.tex_u   = chain[QW].quo[LaneU][TexW-1:0];
    push_data.tex_v   = chain[QW].quo[LaneV][TexW-1:0];
    push_data.clamped = chain[QW].clamped;
  end

  bgv_skid u_skid (
    .clk        (clk),
    .rst        (rst),
    .push_valid (chain[QW].valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .vertex     (vertex)
  );

  a_hold_after_cfg: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> !grid.ready) else $error("grid accepted while coefficients settle");
  a_ndiv_range: assert property (@(posedge clk) disable iff (rst)
    ndiv != '0) else $error("division count zero");
  a_tex_range: assert property (@(posedge clk) disable iff (rst)
    chain[QW].valid |-> (chain[QW].quo[LaneU] <= 18'd65536) &&
                        (chain[QW].quo[LaneV] <= 18'd65536))
    else $error("texture coordinate above one");

endmodule
`default_nettype wire
